FILE: rtl/trial_division_prime_test_assert.svh
// Assertion macros shared by the trial-division prime test RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TDPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tdpt_pkg.sv
// Shared constants and controller/datapath types for the trial-division prime test.
package tdpt_pkg;

    localparam int CAND_WIDTH  = 16;
    localparam int VALUE_WIDTH = 16;
    // Divisors run up to floor(sqrt(max value)) + 1.
    localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
    // Running square of the divisor, one past the largest value.
    localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
    localparam int CNT_WIDTH   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(2);
    localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(4);
    localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(2);

    typedef struct packed {
        logic load;       // capture candidate, restart divisor
        logic div_start;  // start remainder of value by divisor
        logic advance;    // move to next divisor
    } cmd_t;

    typedef struct packed {
        logic below_two;  // value is zero or one
        logic sq_le_v;    // divisor squared still within value
        logic div_done;   // remainder ready
        logic rem_zero;   // remainder is zero
    } status_t;

endpackage

FILE: rtl/tdpt_if.sv
// Handshake channels for candidate items and result items.
interface tdpt_cand_if;
    logic                            valid;
    logic                            ready;
    logic [tdpt_pkg::CAND_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

FILE: rtl/trial_division_prime_test.sv
// Top level of the trial-division prime test: controller, datapath and channel hookup.

// Tests one 16-bit unsigned candidate per item and returns is_prime (1 for a prime,
// 0 for composite, zero or one). Divisors d = 2, 3, ... are tried while d*d <= value;
// the square is kept as a running sum, so no multiplier is needed. Each trial runs a
// bit-serial remainder unit that takes one dividend bit per cycle, plus a test step
// and a done step. An item's time therefore grows with k, the number of divisors
// tried: zero and one need no trial, even values need one, other values with a
// small factor stop early, and a large prime needs the most (k = 254 at most,
// divisors 2 through 255). The remainder unit sets the pace and one item is in work
// at a time. The result sits in an output register, so a new candidate item is
// accepted as soon as the previous verdict is written there, even if the sink has
// not taken it yet. No state is kept between items.
module trial_division_prime_test
(
    input  logic                 clk,
    input  logic                 rst_n,
    tdpt_cand_if.sink            cand,
    tdpt_result_if.source        result
);

    tdpt_pkg::cmd_t    cmd;
    tdpt_pkg::status_t st;

    logic in_ready;
    logic out_valid;
    logic out_prime;

    // Sequence the trials and hold the verdict until the sink takes it.
    tdpt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cand.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .out_prime (out_prime),
        .st        (st),
        .cmd       (cmd)
    );

    // Hold the value, step the divisor and its square, compute remainders.
    tdpt_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .candidate (cand.candidate),
        .st        (st)
    );

    assign cand.ready      = in_ready;
    assign result.valid    = out_valid;
    assign result.is_prime = out_prime;

endmodule

FILE: rtl/tdpt_rem_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`include "trial_division_prime_test_assert.svh"

module tdpt_rem_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tdpt_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [tdpt_pkg::DIV_WIDTH-1:0]   divisor,
    output logic                             done,
    output logic                             rem_zero
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [tdpt_pkg::CNT_WIDTH-1:0]   cnt_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] shift_reg;
    logic [tdpt_pkg::DIV_WIDTH-1:0]   rem_reg;

    logic [tdpt_pkg::DIV_WIDTH:0]     trial;
    logic [tdpt_pkg::DIV_WIDTH:0]     div_ext;
    logic [tdpt_pkg::DIV_WIDTH-1:0]   rem_next;

    // Shift in the next dividend bit; subtract when it fits.
    always_comb
    begin
        trial   = {rem_reg, shift_reg[tdpt_pkg::VALUE_WIDTH-1]};
        div_ext = {1'b0, divisor};
        if (trial >= div_ext)
        begin
            rem_next = tdpt_pkg::DIV_WIDTH'(trial - div_ext);
        end
        else
        begin
            rem_next = tdpt_pkg::DIV_WIDTH'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + tdpt_pkg::CNT_WIDTH'(1);
            if (cnt_reg == tdpt_pkg::CNT_WIDTH'(tdpt_pkg::VALUE_WIDTH - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

    `TDPT_ASSERT_IMP(a_no_restart, start, !busy_reg, "remainder unit restarted while busy")
    `TDPT_ASSERT_NXT(a_start_busy, start, busy_reg && !done_reg, "remainder unit did not start")

endmodule

FILE: rtl/tdpt_datapath.sv
// Datapath: held value, trial divisor, its running square and the remainder unit.
module tdpt_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tdpt_pkg::cmd_t                  cmd,
    input  logic [tdpt_pkg::CAND_WIDTH-1:0] candidate,
    output tdpt_pkg::status_t               st
);

    logic [tdpt_pkg::VALUE_WIDTH-1:0] v_reg;
    logic [tdpt_pkg::DIV_WIDTH-1:0]   d_reg;
    logic [tdpt_pkg::SQ_WIDTH-1:0]    sq_reg;

    logic div_done;
    logic rem_zero;

    // (d+1)^2 = d^2 + 2d + 1
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg  <= tdpt_pkg::VALUE_WIDTH'(candidate);
            d_reg  <= tdpt_pkg::FIRST_DIVISOR;
            sq_reg <= tdpt_pkg::FIRST_SQUARE;
        end
        else if (cmd.advance)
        begin
            d_reg  <= d_reg + tdpt_pkg::DIV_WIDTH'(1);
            sq_reg <= sq_reg + tdpt_pkg::SQ_WIDTH'({d_reg, 1'b1});
        end
    end

    tdpt_rem_unit u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .rem_zero (rem_zero)
    );

    assign st.below_two = (v_reg < tdpt_pkg::SMALLEST_PRIME);
    assign st.sq_le_v   = (sq_reg <= tdpt_pkg::SQ_WIDTH'(v_reg));
    assign st.div_done  = div_done;
    assign st.rem_zero  = rem_zero;

endmodule

FILE: rtl/tdpt_ctrl.sv
// Controller: sequences divisor trials and holds the result output register.
`include "trial_division_prime_test_assert.svh"

module tdpt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_prime,
    input  tdpt_pkg::status_t st,
    output tdpt_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   verdict_reg, verdict_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_prime_reg, out_prime_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_prime_next = out_prime_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (st.below_two)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_FINISH;
                end
                else if (!st.sq_le_v)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (st.div_done)
                begin
                    if (st.rem_zero)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_TEST;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_prime_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
            out_prime_reg <= out_prime_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_prime = out_prime_reg;

    `TDPT_ASSERT_NXT(a_accept_test, in_valid && in_ready, state_reg == ST_TEST, "accepted item did not enter test")
    `TDPT_ASSERT_IMP(a_done_divide, st.div_done, state_reg == ST_DIVIDE, "remainder arrived outside divide")
    `TDPT_ASSERT_NXT(a_small_comp, (state_reg == ST_TEST) && st.below_two, (state_reg == ST_FINISH) && !verdict_reg, "zero or one not reported composite")
    `TDPT_ASSERT_NXT(a_finish_hold, (state_reg == ST_FINISH) && !slot_free, state_reg == ST_FINISH, "verdict dropped while output full")

endmodule
